// ----- rtl/pkmt_pkg.sv -----
// Shared types and constants for the pressed key modifier tracker.
// Used by pkmt_cell and pressed_key_modifier_tracker; depends on nothing.
`default_nettype none

package pkmt_pkg;

  localparam int KEY_W        = 16;
  localparam int MASK_W       = 16;
  localparam int MAX_HELD_DEF = 8;

  // One stored press: mask in the upper half, key in the lower half
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // Row-wide controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic capture;  // register each cell's key match
    logic push;     // shift one place older, new entry enters at the front
    logic pull;     // close the gap behind the first match
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/pressed_key_modifier_tracker.sv -----
// Top level of the pressed key modifier tracker: sequencer, fill count and cell row.
// Depends on pkmt_pkg and pkmt_cell.
`default_nettype none

// Usage:
//   Input beat: raise start with in_cmd (1 press, 0 release), in_key and
//   in_modifier_mask; the beat is taken on a rising edge where busy is low.
//   Result beat: out_valid is high for exactly one cycle with
//   out_modifier_out and out_found; it must be taken in that cycle, the
//   receiver cannot hold it off.
//   A press stores key and mask at the front of a row of MAX_HELD cells,
//   dropping the oldest when full; it reports the input mask, found low.
//   A release reports the mask of the newest entry with the same key and
//   closes the gap, or passes the input mask through with found low.
//   Order: the accepting edge registers the beat; in S_CMP every cell
//   registers its key compare; in S_MOVE the shift along the row and the
//   result register happen on the same edge. busy drops in the strobe
//   cycle, so a new beat may be taken in that cycle.
//   Reset (synchronous, rst_n low) empties the row by clearing the fill
//   count; stored entries are not cleared and are never read until written.
module pressed_key_modifier_tracker #(
  parameter int MAX_HELD = pkmt_pkg::MAX_HELD_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire                          in_cmd,
  input  wire  [pkmt_pkg::KEY_W-1:0]   in_key,
  input  wire  [pkmt_pkg::MASK_W-1:0]  in_modifier_mask,
  output logic                         out_valid,
  output logic [pkmt_pkg::MASK_W-1:0]  out_modifier_out,
  output logic                         out_found
);
  import pkmt_pkg::*;

  localparam int CNT_W = $clog2(MAX_HELD + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_MOVE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [MASK_W-1:0] mask_r;
  logic              out_valid_r;
  logic [MASK_W-1:0] out_modifier_out_r;
  logic              out_found_r;

  ctrl_t             ctrl;
  entry_t            new_entry;
  entry_t            cell_entry [MAX_HELD];
  logic [MAX_HELD:0] hit_chain;
  logic [MAX_HELD-1:0] first_vec;
  logic [MASK_W-1:0] cell_mask [MAX_HELD];
  logic [MASK_W-1:0] match_mask;
  logic              any_hit;

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_modifier_out = out_modifier_out_r;
  assign out_found        = out_found_r;

  assign new_entry.mask = mask_r;
  assign new_entry.key  = key_r;

  // Broadcast row controls
  assign ctrl.capture = (state_r == S_CMP);
  assign ctrl.push    = (state_r == S_MOVE) && cmd_r;
  assign ctrl.pull    = (state_r == S_MOVE) && !cmd_r;

  assign hit_chain[0] = 1'b0;
  assign any_hit      = hit_chain[MAX_HELD];

  // Build the row of cells, newest at index 0
  for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
    entry_t newer;
    entry_t older;

    if (i == 0) begin : g_front
      assign newer = new_entry;
    end else begin : g_mid
      assign newer = cell_entry[i-1];
    end

    if (i == MAX_HELD - 1) begin : g_back
      assign older = cell_entry[i];
    end else begin : g_inner
      assign older = cell_entry[i+1];
    end

    pkmt_cell u_cell (
      .clk         (clk),
      .ctrl_i      (ctrl),
      .in_use_i    (count_r > CNT_W'(i)),
      .key_i       (key_r),
      .newer_i     (newer),
      .older_i     (older),
      .hit_chain_i (hit_chain[i]),
      .entry_o     (cell_entry[i]),
      .hit_chain_o (hit_chain[i+1]),
      .first_o     (first_vec[i]),
      .mask_sel_o  (cell_mask[i])
    );
  end

  // Gather the mask of the single first match
  always_comb begin
    match_mask = '0;
    for (int i = 0; i < MAX_HELD; i++) begin
      match_mask = match_mask | cell_mask[i];
    end
  end

  // Sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Register the result strobe from the move state
      out_valid_r <= (state_r == S_MOVE);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_cmd;
            key_r   <= in_key;
            mask_r  <= in_modifier_mask;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_MOVE;
        end
        S_MOVE: begin
          if (cmd_r) begin
            out_modifier_out_r <= mask_r;
            out_found_r        <= 1'b0;
            if (count_r != CNT_W'(MAX_HELD)) begin
              count_r <= count_r + 1'b1;
            end
          end else if (any_hit) begin
            out_modifier_out_r <= match_mask;
            out_found_r        <= 1'b1;
            count_r            <= count_r - 1'b1;
          end else begin
            out_modifier_out_r <= mask_r;
            out_found_r        <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_HELD))
    else $error("fill count beyond row length");

  a_one_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> $onehot0(first_vec))
    else $error("more than one first match in the row");

  a_press_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && cmd_r))
    else $error("press reported as found");

  a_release_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && !cmd_r && any_hit) |=> (count_r == $past(count_r) - 1'b1))
    else $error("matched release did not shrink the row");
`endif

endmodule

`default_nettype wire

// ----- rtl/pkmt_cell.sv -----
// One slot of the held-key row: a stored entry and its registered match bit.
// Depends on pkmt_pkg for entry_t and ctrl_t.
`default_nettype none

module pkmt_cell (
  input  wire                          clk,
  input  pkmt_pkg::ctrl_t              ctrl_i,
  input  wire                          in_use_i,
  input  wire  [pkmt_pkg::KEY_W-1:0]   key_i,
  input  pkmt_pkg::entry_t             newer_i,
  input  pkmt_pkg::entry_t             older_i,
  input  wire                          hit_chain_i,
  output pkmt_pkg::entry_t             entry_o,
  output logic                         hit_chain_o,
  output logic                         first_o,
  output logic [pkmt_pkg::MASK_W-1:0]  mask_sel_o
);
  import pkmt_pkg::*;

  entry_t entry_r;
  logic   hit_r;

  // Pass the hit chain on; this cell is the first match if nothing newer hit
  assign hit_chain_o = hit_chain_i | hit_r;
  assign first_o     = hit_r & ~hit_chain_i;
  assign mask_sel_o  = first_o ? entry_r.mask : '0;
  assign entry_o     = entry_r;

  // Compare against the input key, then shift on a press or pull on a release
  always_ff @(posedge clk) begin
    if (ctrl_i.capture) begin
      hit_r <= in_use_i && (entry_r.key == key_i);
    end
    if (ctrl_i.push) begin
      entry_r <= newer_i;
    end else if (ctrl_i.pull && hit_chain_o) begin
      entry_r <= older_i;
    end
  end

endmodule

`default_nettype wire
